// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the tile map checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tmff_pkg.sv =====
// ----------------------------------------------------------------------------
// tmff_pkg
// Geometry constants, request codes, cell position types and the neighbor
// step interface.
// ----------------------------------------------------------------------------
package tmff_pkg;

	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 128;
	localparam int TILE_BITS  = 8;

	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W     = $clog2(CELL_TOTAL);
	localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
	localparam int CFG_W      = 8;

	// request kinds
	typedef enum logic [1:0] {
		KIND_SET   = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAP_COLS = 2'd0,
		CFG_MAP_ROWS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

	// neighbor visiting order of the fill walk
	typedef enum logic [1:0] {
		NB_RIGHT = 2'd0,
		NB_LEFT  = 2'd1,
		NB_DOWN  = 2'd2,
		NB_UP    = 2'd3
	} nb_dir_t;

	typedef struct packed {
		logic              ok;
		pos_t              pos;
		logic [ADDR_W-1:0] addr;
	} nbr_t;

	// row-major cell address
	function automatic logic [ADDR_W-1:0] cell_addr(input pos_t p);
		return ADDR_W'(int'(p.row) * MAX_COLS + int'(p.col));
	endfunction

endpackage

// ===== hdl/tmff_nbr.sv =====
// ----------------------------------------------------------------------------
// tmff_nbr
// Neighbor step unit: one 4-way neighbor of a cell, its bounds check and its
// grid address. Shared by every step of the fill walk.
// ----------------------------------------------------------------------------
module tmff_nbr (
	input  tmff_pkg::pos_t                 cur,
	input  tmff_pkg::nb_dir_t              dir,
	input  logic [tmff_pkg::CFG_W-1:0]     eff_cols,
	input  logic [tmff_pkg::CFG_W-1:0]     eff_rows,
	output tmff_pkg::nbr_t                 nbr
);

	tmff_pkg::pos_t npos;
	logic           nok;

	always_comb begin
		npos = cur;
		nok  = 1'b0;
		case (dir)
			tmff_pkg::NB_RIGHT: begin
				nok      = (int'(cur.col) + 1) < int'(eff_cols);
				npos.col = cur.col + 1'b1;
			end
			tmff_pkg::NB_LEFT: begin
				nok      = (cur.col != '0);
				npos.col = cur.col - 1'b1;
			end
			tmff_pkg::NB_DOWN: begin
				nok      = (int'(cur.row) + 1) < int'(eff_rows);
				npos.row = cur.row + 1'b1;
			end
			tmff_pkg::NB_UP: begin
				nok      = (cur.row != '0);
				npos.row = cur.row - 1'b1;
			end
			default: begin
				nok = 1'b0;
			end
		endcase
	end

	assign nbr.ok   = nok;
	assign nbr.pos  = npos;
	assign nbr.addr = tmff_pkg::cell_addr(npos);

endmodule

// ===== hdl/tile_map_flood_fill.sv =====
// ----------------------------------------------------------------------------
// tile_map_flood_fill
// Tile map grid with set, read, clear and 4-way flood fill requests.
// ----------------------------------------------------------------------------
// Result: done is registered from the S_EXEC state that follows a taken request,
//   for every kind; the receiver cannot stall, so done is a one-cycle pulse.
// Busy: set and read hold busy only through S_EXEC; no request is taken while
//   busy. A fill holds busy through each filled cell on the shared grid read port.
// An in-map clear, a map_cols/map_rows write and reset run a 16384-cell zeroing sweep.
// Reset: arst_n clears control state and starts that sweep at once.
// ----------------------------------------------------------------------------
module tile_map_flood_fill (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [6:0] col,
	input  logic [6:0] row,
	input  logic [7:0] tile_value,
	input  logic       only_if_empty,
	// result channel
	output logic       done,
	output logic [7:0] old_value,
	output logic       in_bounds,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam logic [tmff_pkg::ADDR_W-1:0] CLR_LAST =
		tmff_pkg::ADDR_W'(tmff_pkg::CELL_TOTAL - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_POP,
		S_POP_WAIT,
		S_NB_ISSUE,
		S_NB_CHECK
	} state_t;

	state_t                               state_q;
	tmff_pkg::pos_t                       cur_pos_q;
	logic [tmff_pkg::ADDR_W-1:0]          cur_addr_q;
	tmff_pkg::kind_t                      kind_q;
	logic [tmff_pkg::TILE_BITS-1:0]       tile_q;
	logic [tmff_pkg::TILE_BITS-1:0]       target_q;
	logic                                 only_empty_q;
	logic                                 ib_q;
	logic [tmff_pkg::ADDR_W-1:0]          clr_addr_q;
	logic [tmff_pkg::CNT_W-1:0]           cnt_q;
	tmff_pkg::nb_dir_t                    nb_q;
	tmff_pkg::pos_t                       nb_pos_q;
	logic [tmff_pkg::ADDR_W-1:0]          nb_addr_q;
	logic                                 done_q;
	logic [7:0]                           old_value_q;
	logic                                 in_bounds_q;
	logic [tmff_pkg::CFG_W-1:0]           cols_q;
	logic [tmff_pkg::CFG_W-1:0]           rows_q;

	// storage: tile grid and the fill stack of pending cells
	logic [tmff_pkg::TILE_BITS-1:0]       grid_mem [tmff_pkg::CELL_TOTAL];
	tmff_pkg::pos_t                       stk_mem  [tmff_pkg::CELL_TOTAL];
	logic [tmff_pkg::TILE_BITS-1:0]       grid_rd_q;
	tmff_pkg::pos_t                       stk_rd_q;

	logic [tmff_pkg::CFG_W-1:0]           eff_cols;
	logic [tmff_pkg::CFG_W-1:0]           eff_rows;
	logic                                 accept;
	logic                                 in_ib;
	tmff_pkg::pos_t                       in_pos;
	logic                                 cfg_wr;
	logic                                 cfg_hit;
	logic                                 fill_go;
	logic                                 nb_match;
	logic [tmff_pkg::CNT_W-1:0]           cnt_dec;
	tmff_pkg::nbr_t                       nbr;

	logic                                 gw_en;
	logic [tmff_pkg::ADDR_W-1:0]          gw_addr;
	logic [tmff_pkg::TILE_BITS-1:0]       gw_data;
	logic [tmff_pkg::ADDR_W-1:0]          gr_addr;
	logic                                 sw_en;
	logic [tmff_pkg::ADDR_W-1:0]          sw_addr;
	tmff_pkg::pos_t                       sw_data;

	// geometry beyond the physical grid acts as the grid size
	assign eff_cols = (int'(cols_q) > tmff_pkg::MAX_COLS) ?
		tmff_pkg::CFG_W'(tmff_pkg::MAX_COLS) : cols_q;
	assign eff_rows = (int'(rows_q) > tmff_pkg::MAX_ROWS) ?
		tmff_pkg::CFG_W'(tmff_pkg::MAX_ROWS) : rows_q;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_ib     = ({1'b0, col} < eff_cols) && ({1'b0, row} < eff_rows);
	assign in_pos.col = tmff_pkg::COL_W'(col);
	assign in_pos.row = tmff_pkg::ROW_W'(row);

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == tmff_pkg::CFG_MAP_COLS ||
		cfg_index == tmff_pkg::CFG_MAP_ROWS);

	// fill runs only if it changes something; grid_rd_q holds the seed here
	assign fill_go = ib_q && (kind_q == tmff_pkg::KIND_FILL) &&
		!(only_empty_q && (grid_rd_q != '0)) && (grid_rd_q != tile_q);

	assign nb_match = (grid_rd_q == target_q);
	assign cnt_dec  = cnt_q - tmff_pkg::CNT_W'(1);

	tmff_nbr u_nbr (
		.cur      (cur_pos_q),
		.dir      (nb_q),
		.eff_cols (eff_cols),
		.eff_rows (eff_rows),
		.nbr      (nbr)
	);

	// memory port steering
	always_comb begin
		gw_en   = 1'b0;
		gw_addr = cur_addr_q;
		gw_data = tile_q;
		sw_en   = 1'b0;
		sw_addr = cnt_q[tmff_pkg::ADDR_W-1:0];
		sw_data = nb_pos_q;
		case (state_q)
			S_CLEAR: begin
				gw_en   = 1'b1;
				gw_addr = clr_addr_q;
				gw_data = '0;
			end
			S_EXEC: begin
				if (ib_q && (kind_q == tmff_pkg::KIND_SET)) begin
					gw_en = 1'b1;
				end
				if (fill_go) begin
					// seed is recolored and pushed as the first stack entry
					gw_en   = 1'b1;
					sw_en   = 1'b1;
					sw_addr = '0;
					sw_data = cur_pos_q;
				end
			end
			S_NB_CHECK: begin
				if (nb_match) begin
					gw_en   = 1'b1;
					gw_addr = nb_addr_q;
					sw_en   = 1'b1;
				end
			end
			default: begin
				gw_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:     gr_addr = tmff_pkg::cell_addr(in_pos);
			S_NB_ISSUE: gr_addr = nbr.addr;
			default:    gr_addr = cur_addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (gw_en) begin
			grid_mem[gw_addr] <= gw_data;
		end
		grid_rd_q <= grid_mem[gr_addr];
	end

	always_ff @(posedge clk) begin
		if (sw_en) begin
			stk_mem[sw_addr] <= sw_data;
		end
		stk_rd_q <= stk_mem[cnt_dec[tmff_pkg::ADDR_W-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			cnt_q        <= '0;
			nb_q         <= tmff_pkg::NB_RIGHT;
			done_q       <= 1'b0;
			cols_q       <= tmff_pkg::CFG_W'(10);
			rows_q       <= tmff_pkg::CFG_W'(10);
			cur_pos_q    <= '0;
			cur_addr_q   <= '0;
			kind_q       <= tmff_pkg::KIND_SET;
			tile_q       <= '0;
			target_q     <= '0;
			only_empty_q <= 1'b0;
			ib_q         <= 1'b0;
			nb_pos_q     <= '0;
			nb_addr_q    <= '0;
			old_value_q  <= '0;
			in_bounds_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			if (state_q == S_EXEC) begin
				in_bounds_q <= ib_q;
				old_value_q <= ib_q ? 8'(grid_rd_q) : 8'd0;
			end

			// geometry writes also zero the map; they drop any walk in flight
			if (cfg_hit) begin
				state_q    <= S_CLEAR;
				clr_addr_q <= '0;
				cnt_q      <= '0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (clr_addr_q == CLR_LAST) begin
							state_q <= S_IDLE;
						end else begin
							clr_addr_q <= clr_addr_q + 1'b1;
						end
					end
					S_IDLE: begin
						if (accept) begin
							kind_q       <= tmff_pkg::kind_t'(kind);
							tile_q       <= tmff_pkg::TILE_BITS'(tile_value);
							only_empty_q <= only_if_empty;
							ib_q         <= in_ib;
							cur_pos_q    <= in_pos;
							cur_addr_q   <= tmff_pkg::cell_addr(in_pos);
							state_q      <= S_EXEC;
						end
					end
					S_EXEC: begin
						target_q <= grid_rd_q;
						if (ib_q && (kind_q == tmff_pkg::KIND_CLEAR)) begin
							clr_addr_q <= '0;
							state_q    <= S_CLEAR;
						end else if (fill_go) begin
							cnt_q   <= tmff_pkg::CNT_W'(1);
							state_q <= S_POP;
						end else begin
							state_q <= S_IDLE;
						end
					end
					S_POP: begin
						if (cnt_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_dec;
							state_q <= S_POP_WAIT;
						end
					end
					S_POP_WAIT: begin
						cur_pos_q <= stk_rd_q;
						nb_q      <= tmff_pkg::NB_RIGHT;
						state_q   <= S_NB_ISSUE;
					end
					S_NB_ISSUE: begin
						if (nbr.ok) begin
							nb_pos_q  <= nbr.pos;
							nb_addr_q <= nbr.addr;
							state_q   <= S_NB_CHECK;
						end else if (nb_q == tmff_pkg::NB_UP) begin
							state_q <= S_POP;
						end else begin
							nb_q <= tmff_pkg::nb_dir_t'(nb_q + 2'd1);
						end
					end
					S_NB_CHECK: begin
						if (nb_match) begin
							cnt_q <= cnt_q + tmff_pkg::CNT_W'(1);
						end
						if (nb_q == tmff_pkg::NB_UP) begin
							state_q <= S_POP;
						end else begin
							nb_q    <= tmff_pkg::nb_dir_t'(nb_q + 2'd1);
							state_q <= S_NB_ISSUE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end

			if (cfg_wr && (cfg_index == tmff_pkg::CFG_MAP_COLS)) begin
				cols_q <= cfg_data;
			end
			if (cfg_wr && (cfg_index == tmff_pkg::CFG_MAP_ROWS)) begin
				rows_q <= cfg_data;
			end
		end
	end

	assign done      = done_q;
	assign old_value = old_value_q;
	assign in_bounds = in_bounds_q;

endmodule

// ===== hdl/tmff_checker.sv =====
// ----------------------------------------------------------------------------
// tmff_checker
// Port-level timing and value checks of the tile map, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmff_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] old_value,
	input logic       in_bounds,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [1:0] cfg_index
);

	logic req_taken;
	logic oob_done;
	logic geom_wr;

	assign req_taken = start && !busy && !(cfg_valid && cfg_ready);
	assign oob_done  = done && !in_bounds;
	assign geom_wr   = cfg_valid && cfg_ready &&
		(cfg_index == tmff_pkg::CFG_MAP_COLS || cfg_index == tmff_pkg::CFG_MAP_ROWS);

	// every request taken without a configuration write gives its result strobe
	`ASSERT_HOLDS(a_req_result, clk, arst_n, req_taken |=> ##1 done, "request without result")

	// result strobe is a single-cycle pulse
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held over two cycles")

	// outside the map the reported value is zero
	`ASSERT_HOLDS(a_oob_zero, clk, arst_n, oob_done |-> (old_value == 8'd0), "out-of-map value")

	// geometry writes start the zeroing sweep
	`ASSERT_NEXT(a_cfg_clear, clk, arst_n, geom_wr, busy, "geometry write left block idle")

endmodule

bind tile_map_flood_fill tmff_checker u_tmff_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tile_map_flood_fill: a short table of directed
// requests, then random set/fill/read/clear traffic over several map
// geometries, each result checked against a behavioral grid mirror or a hand-written answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		tmff_pkg::kind_t kind;
		logic [6:0]      col;
		logic [6:0]      row;
		logic [7:0]      tile_value;
		logic            only_if_empty;
	} tile_req_t;

	typedef struct packed {
		logic [7:0] old_value;
		logic       in_bounds;
	} cell_report_t;

	// one directed row: the request, and a hand-written answer when typed is set
	typedef struct packed {
		tile_req_t    req;
		logic         typed;
		cell_report_t want;
	} stim_row_t;

	// one random phase: geometry, request count, whether fills are allowed
	typedef struct packed {
		logic [7:0] cols;
		logic [7:0] rows;
		logic [11:0] items;
		logic        fills_ok;
	} geom_phase_t;

	localparam logic [7:0] TILE_MASK = 8'((1 << tmff_pkg::TILE_BITS) - 1);
	localparam int N_OPENING = 22;
	localparam int N_PHASES  = 7;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] kind;
	logic [6:0] col;
	logic [6:0] row;
	logic [7:0] tile_value;
	logic       only_if_empty;
	logic       done;
	logic [7:0] old_value;
	logic       in_bounds;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	tile_map_flood_fill dut (.*);

	// Mirror of the block: grid, geometry registers and the fill stack.
	logic [7:0]  grid_mirror [tmff_pkg::CELL_TOTAL];
	int unsigned fill_stack  [tmff_pkg::CELL_TOTAL];
	int unsigned fill_depth;
	logic [7:0]  map_cols_set;
	logic [7:0]  map_rows_set;

	// Reports still owed by the block, oldest first.
	cell_report_t cell_reports [$];

	int unsigned issued, fills, clears, outside, geometries, checked, mismatches;
	int unsigned clears_left;

	stim_row_t   opening_rows [N_OPENING];
	geom_phase_t phases [N_PHASES];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hang guard. The slowest expected run is about 30 zeroing sweeps, one
	// whole-grid fill, small fills and idle gaps; the timeout allows several
	// times that.
	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic int unsigned span(input logic [7:0] v, input int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic void wipe_mirror();
		foreach (grid_mirror[i])
			grid_mirror[i] = '0;
	endfunction

	// repaint a matching neighbor and push it on the walk stack
	function automatic void flood_visit(input int unsigned at, input logic [7:0] from,
			input logic [7:0] to);
		if (grid_mirror[at] == from) begin
			grid_mirror[at] = to;
			fill_stack[fill_depth] = at;
			fill_depth++;
		end
	endfunction

	function automatic cell_report_t predict_cell_report(input tile_req_t r);
		cell_report_t rep;
		int unsigned  w, h, seed, at, c, rr;
		logic [7:0]   prior, paint;
		rep = '0;
		w = span(map_cols_set, tmff_pkg::MAX_COLS);
		h = span(map_rows_set, tmff_pkg::MAX_ROWS);
		// outside the map: nothing changes, report zeros
		if (r.col >= w || r.row >= h)
			return rep;
		seed  = r.row * tmff_pkg::MAX_COLS + r.col;
		prior = grid_mirror[seed];
		paint = r.tile_value & TILE_MASK;
		case (r.kind)
			tmff_pkg::KIND_SET: begin
				grid_mirror[seed] = paint;
			end
			tmff_pkg::KIND_FILL: begin
				// skipped when the seed already holds the new tile, or when
				// only an empty seed may be filled and this one is not
				if (!(r.only_if_empty && prior != 0) && prior != paint) begin
					fill_depth = 0;
					flood_visit(seed, prior, paint);
					while (fill_depth > 0) begin
						fill_depth--;
						at = fill_stack[fill_depth];
						c  = at % tmff_pkg::MAX_COLS;
						rr = at / tmff_pkg::MAX_COLS;
						if (c + 1 < w)  flood_visit(at + 1, prior, paint);
						if (c > 0)      flood_visit(at - 1, prior, paint);
						if (rr + 1 < h) flood_visit(at + tmff_pkg::MAX_COLS, prior, paint);
						if (rr > 0)     flood_visit(at - tmff_pkg::MAX_COLS, prior, paint);
					end
				end
			end
			tmff_pkg::KIND_CLEAR: begin
				wipe_mirror();
			end
			default: begin
			end
		endcase
		rep.old_value = prior;
		rep.in_bounds = 1'b1;
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Random requests: mostly in-map positions, tiles from a small palette so
	// that fills meet sizable regions, and a capped number of clears since
	// each one costs a full zeroing sweep.
	// ------------------------------------------------------------------------
	function automatic tile_req_t random_request(input logic fills_ok);
		tile_req_t   r;
		int unsigned roll, w, h;
		w    = span(map_cols_set, tmff_pkg::MAX_COLS);
		h    = span(map_rows_set, tmff_pkg::MAX_ROWS);
		roll = $urandom_range(999);
		if (roll < 5 && clears_left > 0) begin
			r.kind = tmff_pkg::KIND_CLEAR;
			clears_left--;
		end else if (roll < 400)
			r.kind = tmff_pkg::KIND_SET;
		else if (roll < 700)
			r.kind = fills_ok ? tmff_pkg::KIND_FILL : tmff_pkg::KIND_SET;
		else
			r.kind = tmff_pkg::KIND_READ;
		if (w == 0 || h == 0 || $urandom_range(9) == 0) begin
			r.col = 7'($urandom_range(127));
			r.row = 7'($urandom_range(127));
		end else begin
			r.col = 7'($urandom_range(w - 1));
			r.row = 7'($urandom_range(h - 1));
		end
		r.tile_value    = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(3));
		r.only_if_empty = (r.kind == tmff_pkg::KIND_FILL) ? ($urandom_range(3) == 0)
				: 1'($urandom_range(1));
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. Inputs move on the falling edge; a request is taken at
	// the rising edge where start is high and busy low. start is left high on
	// return so back-to-back requests never drop it within one step.
	// ------------------------------------------------------------------------
	task automatic issue(input tile_req_t r, input logic typed, input cell_report_t want);
		cell_report_t guess;
		int unsigned  idle_pct;
		// sender gaps: 21% for the first third, 51% for the second, none after
		idle_pct = (issued < 630) ? 21 : (issued < 1260) ? 51 : 0;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start         = 1'b1;
		kind          = r.kind;
		col           = r.col;
		row           = r.row;
		tile_value    = r.tile_value;
		only_if_empty = r.only_if_empty;
		do
			@(posedge clk);
		while (busy);
		guess = predict_cell_report(r);
		cell_reports.push_back(typed ? want : guess);
		issued++;
		if (!guess.in_bounds)
			outside++;
		if (r.kind == tmff_pkg::KIND_FILL)
			fills++;
		if (r.kind == tmff_pkg::KIND_CLEAR)
			clears++;
	endtask

	// drop start and wait for every owed report and for the block to go idle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (cell_reports.size() != 0 || busy)
			@(negedge clk);
	endtask

	// geometry writes happen only with the block drained; each one also
	// zeroes the map
	task automatic write_geometry(input tmff_pkg::cfg_reg_t which, input logic [7:0] value);
		drain();
		cfg_valid = 1'b1;
		cfg_index = which;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (which == tmff_pkg::CFG_MAP_COLS)
			map_cols_set = value;
		else
			map_rows_set = value;
		wipe_mirror();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rows);
		if (cols != map_cols_set)
			write_geometry(tmff_pkg::CFG_MAP_COLS, cols);
		if (rows != map_rows_set)
			write_geometry(tmff_pkg::CFG_MAP_ROWS, rows);
		geometries++;
	endtask

	// ------------------------------------------------------------------------
	// Result checker: every strobe must match the oldest owed report.
	// ------------------------------------------------------------------------
	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		cell_report_t owed;
		if (arst_n && done) begin
			if (cell_reports.size() == 0) begin
				log_mismatch($sformatf("result with no request outstanding: old %02h in %0b",
						old_value, in_bounds));
			end else begin
				owed = cell_reports.pop_front();
				checked++;
				if (old_value !== owed.old_value)
					log_mismatch($sformatf("old_value expected %02h got %02h",
							owed.old_value, old_value));
				if (in_bounds !== owed.in_bounds)
					log_mismatch($sformatf("in_bounds expected %0b got %0b",
							owed.in_bounds, in_bounds));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		tile_req_t r;
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = tmff_pkg::KIND_SET;
		col           = '0;
		row           = '0;
		tile_value    = '0;
		only_if_empty = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = tmff_pkg::CFG_MAP_COLS;
		cfg_data      = '0;
		map_cols_set  = 8'd10;
		map_rows_set  = 8'd10;
		wipe_mirror();
		issued = 0; fills = 0; clears = 0; outside = 0;
		checked = 0; mismatches = 0; geometries = 1;
		clears_left = 12;

		// Directed requests on the 10x10 map left by reset.
		opening_rows = '{
			// fresh map reads zero; just outside the right and bottom edges is flagged
			'{'{tmff_pkg::KIND_READ,  7'd0,   7'd0,   8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1}},
			'{'{tmff_pkg::KIND_READ,  7'd9,   7'd9,   8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1}},
			'{'{tmff_pkg::KIND_READ,  7'd10,  7'd0,   8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_READ,  7'd0,   7'd10,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_SET,   7'd127, 7'd127, 8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_SET,   7'd0,   7'd0,   8'hFF, 1'b0}, 1'b1, '{8'h00, 1'b1}},
			'{'{tmff_pkg::KIND_READ,  7'd0,   7'd0,   8'h00, 1'b0}, 1'b1, '{8'hFF, 1'b1}},
			'{'{tmff_pkg::KIND_SET,   7'd5,   7'd5,   8'h80, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			// empty-only fill from a zero seed floods the open area
			'{'{tmff_pkg::KIND_FILL,  7'd1,   7'd0,   8'h55, 1'b1}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_READ,  7'd9,   7'd9,   8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			// no-effect fills (occupied seed with empty-only, same tile), then repainting fills
			'{'{tmff_pkg::KIND_FILL,  7'd5,   7'd5,   8'h55, 1'b1}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_FILL,  7'd5,   7'd5,   8'h80, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_FILL,  7'd0,   7'd0,   8'h55, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_FILL,  7'd3,   7'd3,   8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_READ,  7'd5,   7'd5,   8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			// clear outside the map does nothing
			'{'{tmff_pkg::KIND_CLEAR, 7'd10,  7'd10,  8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_READ,  7'd5,   7'd5,   8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_FILL,  7'd0,   7'd127, 8'hAA, 1'b1}, 1'b1, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_SET,   7'd9,   7'd0,   8'h7F, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_CLEAR, 7'd9,   7'd0,   8'h00, 1'b1}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_READ,  7'd5,   7'd5,   8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
			'{'{tmff_pkg::KIND_SET,   7'd3,   7'd4,   8'h01, 1'b0}, 1'b0, '{8'h00, 1'b0}}
		};

		// Random phases. 255 stands in for an oversized register, 0 for an
		// empty map; the rest keep fills cheap.
		phases = '{
			'{8'd255, 8'd1,   12'd180, 1'b1},
			'{8'd1,   8'd128, 12'd180, 1'b1},
			'{8'd0,   8'd128, 12'd40,  1'b1},
			'{8'd8,   8'd8,   12'd300, 1'b1},
			'{8'd16,  8'd6,   12'd300, 1'b1},
			'{8'd5,   8'd20,  12'd300, 1'b1},
			'{8'd12,  8'd12,  12'd500, 1'b1}
		};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (opening_rows[i])
			issue(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);

		foreach (phases[p]) begin
			set_geometry(phases[p].cols, phases[p].rows);
			repeat (phases[p].items)
				issue(random_request(phases[p].fills_ok), 1'b0, '0);
		end

		// Full 128x128 map: one flood across the whole zeroed grid, corner
		// reads, then set/read traffic only since any random fill would
		// walk most of the grid.
		set_geometry(8'd255, 8'd255);
		issue('{tmff_pkg::KIND_FILL, 7'd127, 7'd127, 8'hA5, 1'b1}, 1'b0, '0);
		issue('{tmff_pkg::KIND_READ, 7'd0,   7'd0,   8'h00, 1'b0}, 1'b0, '0);
		issue('{tmff_pkg::KIND_FILL, 7'd64,  7'd64,  8'h3C, 1'b1}, 1'b0, '0);
		issue('{tmff_pkg::KIND_READ, 7'd127, 7'd0,   8'h00, 1'b0}, 1'b0, '0);
		repeat (60) begin
			r = random_request(1'b0);
			if (r.kind == tmff_pkg::KIND_CLEAR)
				r.kind = tmff_pkg::KIND_READ;
			issue(r, 1'b0, '0);
		end

		// settle: all reports in, then a margin for trailing strobes
		drain();
		repeat (40) @(posedge clk);

		$display("Covered %0d requests over %0d map geometries: %0d fills, %0d clears, %0d outside the map.",
				issued, geometries, fills, clears, outside);
		$display("Checked %0d results, %0d mismatches.", checked, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tmff_pkg.sv
hdl/tmff_nbr.sv
hdl/tile_map_flood_fill.sv
hdl/tmff_checker.sv
tb/tb.sv
